@@ design/sorted_interval_merge_defines.svh @@
// Assertion macros for the interval merger; only simrg_queue uses them.
`ifndef SORTED_INTERVAL_MERGE_DEFINES_SVH
`define SORTED_INTERVAL_MERGE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define SIM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SIM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/simrg_pkg.sv @@
// Types, codes and constants of the sorted interval merger.
package simrg_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned TOTAL_W     = 48;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic KIND_IV  = 1'b0;
  localparam logic KIND_END = 1'b1;

  typedef enum logic [1:0] {
    STAT_MERGED   = 2'd0,
    STAT_UNSORTED = 2'd1,
    STAT_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_IV  = 2'd0,
    OP_END = 2'd1,
    OP_ERR = 2'd2
  } op_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] seq_id;
    logic [31:0] iv_start;
    logic [31:0] iv_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        out_seq;
    logic [31:0]        out_start;
    logic [31:0]        out_end;
    logic [TOTAL_W-1:0] input_total;
    logic [TOTAL_W-1:0] merged_total;
  } out_item_t;

  // Classified word handed from front to back.
  typedef struct packed {
    op_t                op;
    logic [15:0]        seq;
    logic [31:0]        start;
    logic [31:0]        stop;
    logic [TOTAL_W-1:0] in_total;
  } q_item_t;

  function automatic logic [31:0] span_len(input logic [31:0] s, input logic [31:0] e);
    span_len = (e > s) ? (e - s) : 32'd0;
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] acc,
                                                 input logic [31:0] v);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, acc} + (TOTAL_W+1)'(v);
    sat_add = (sum >= {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
  endfunction

endpackage

@@ design/sorted_interval_merge.sv @@
// Top level of the sorted interval merger: front, word queue, back.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+-----------------------------
//   in_     | input     | in_valid/in_stall  | in_item_t: kind, id, start, end
//   out_    | output    | out_valid/out_stall| out_item_t: status, block, totals
//   cfg_    | input     | cfg_valid/cfg_ready| sort_check bit (always ready)
//
// One word per cycle sustained while neither in_stall nor out_stall holds the flow; a word that
// causes a result passes the queue entry, written at the accepting edge, then the result register.
// Synchronous active-low reset clears flags, pointers and totals; no clearing pass.
// in_stall rises only when the QDEPTH-entry queue is full.
// out_stall holds a valid result register and then stops the back end from draining the queue.
module sorted_interval_merge #(
  parameter int unsigned QDEPTH = simrg_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  simrg_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output simrg_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  logic               push, pop, q_full, q_valid;
  simrg_pkg::q_item_t push_item, q_head;

  simrg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  simrg_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_head    (q_head)
  );

  simrg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ design/simrg_front.sv @@
// Front end: takes words, checks sort order, keeps the input total, classifies.
module simrg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  simrg_pkg::in_item_t in_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data,
  input  logic                q_full,
  output logic                push,
  output simrg_pkg::q_item_t  push_item
);

  logic                          sort_check_r;
  logic                          halted_r, halted_nxt;
  logic                          last_valid_r, last_valid_nxt;
  logic [15:0]                   last_seq_r, last_seq_nxt;
  logic [31:0]                   last_start_r, last_start_nxt;
  logic [simrg_pkg::TOTAL_W-1:0] sum_in_r, sum_in_nxt;

  logic                          accept;
  logic                          is_end;
  logic                          unsorted;
  logic [simrg_pkg::TOTAL_W-1:0] sum_upd;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = accept && !halted_r;

  always_comb begin
    is_end   = (in_data.kind == simrg_pkg::KIND_END);
    unsorted = last_valid_r && (in_data.seq_id == last_seq_r) &&
               (in_data.iv_start < last_start_r);
    sum_upd  = simrg_pkg::sat_add(sum_in_r,
                                  simrg_pkg::span_len(in_data.iv_start, in_data.iv_end));

    halted_nxt     = halted_r;
    last_valid_nxt = last_valid_r;
    last_seq_nxt   = last_seq_r;
    last_start_nxt = last_start_r;
    sum_in_nxt     = sum_in_r;

    push_item.seq      = in_data.seq_id;
    push_item.start    = in_data.iv_start;
    push_item.stop     = in_data.iv_end;
    push_item.in_total = sum_in_r;

    priority if (is_end) begin
      push_item.op   = simrg_pkg::OP_END;
      last_valid_nxt = 1'b0;
    end else if (unsorted && sort_check_r) begin
      push_item.op = simrg_pkg::OP_ERR;
      halted_nxt   = 1'b1;
    end else begin
      push_item.op       = simrg_pkg::OP_IV;
      push_item.in_total = sum_upd;
      sum_in_nxt         = sum_upd;
      // an unsorted start merged silently does not move the check point
      if (!unsorted) begin
        last_valid_nxt = 1'b1;
        last_seq_nxt   = in_data.seq_id;
        last_start_nxt = in_data.iv_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_check_r <= 1'b1;
      halted_r     <= 1'b0;
      last_valid_r <= 1'b0;
      last_seq_r   <= '0;
      last_start_r <= '0;
      sum_in_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sort_check_r <= cfg_data;
      end
      if (push) begin
        halted_r     <= halted_nxt;
        last_valid_r <= last_valid_nxt;
        last_seq_r   <= last_seq_nxt;
        last_start_r <= last_start_nxt;
        sum_in_r     <= sum_in_nxt;
      end
    end
  end

endmodule

@@ design/simrg_queue.sv @@
// Short FIFO of classified words between front and back.
`include "sorted_interval_merge_defines.svh"

module simrg_queue #(
  parameter int unsigned QDEPTH = simrg_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  simrg_pkg::q_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output simrg_pkg::q_item_t q_head
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  simrg_pkg::q_item_t mem_r [QDEPTH];
  logic [PW-1:0]      wptr_r, rptr_r;
  logic [CW-1:0]      count_r, count_nxt;

  assign full    = (count_r == CW'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_head  = mem_r[rptr_r];

  always_comb begin
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  `SIM_ASSERT(a_no_overflow, push |-> !full, "push into full queue")
  `SIM_ASSERT(a_no_underflow, pop |-> q_valid, "pop from empty queue")
  `SIM_ASSERT(a_count_up, (push && !pop) |=> count_r == $past(count_r) + 1'b1, "count lost a push")
  `SIM_ASSERT(a_count_down, (pop && !push) |=> count_r == $past(count_r) - 1'b1, "count lost a pop")
  `SIM_ASSERT(a_count_range, count_r <= CW'(QDEPTH), "count beyond depth")

endmodule

@@ design/simrg_back.sv @@
// Back end: holds the open block, merges, keeps merged total, drives the result register.
module simrg_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  simrg_pkg::q_item_t   q_head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output simrg_pkg::out_item_t out_data
);

  logic                          open_r, open_nxt;
  logic [15:0]                   bseq_r, bseq_nxt;
  logic [31:0]                   bstart_r, bstart_nxt;
  logic [31:0]                   bend_r, bend_nxt;
  logic [simrg_pkg::TOTAL_W-1:0] msum_r, msum_nxt;
  logic                          out_valid_r, out_valid_nxt;
  simrg_pkg::out_item_t          out_data_r, out_data_nxt;

  logic                          emit;
  logic [simrg_pkg::TOTAL_W-1:0] msum_upd;
  logic                          new_block;

  assign pop       = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    msum_upd  = simrg_pkg::sat_add(msum_r, simrg_pkg::span_len(bstart_r, bend_r));
    new_block = !open_r || (q_head.seq != bseq_r) || (q_head.start > bend_r);

    open_nxt   = open_r;
    bseq_nxt   = bseq_r;
    bstart_nxt = bstart_r;
    bend_nxt   = bend_r;
    msum_nxt   = msum_r;
    emit       = 1'b0;

    out_data_nxt.status       = simrg_pkg::STAT_MERGED;
    out_data_nxt.out_seq      = bseq_r;
    out_data_nxt.out_start    = bstart_r;
    out_data_nxt.out_end      = bend_r;
    out_data_nxt.input_total  = q_head.in_total;
    out_data_nxt.merged_total = msum_upd;

    unique case (q_head.op)
      simrg_pkg::OP_END: begin
        emit     = 1'b1;
        open_nxt = 1'b0;
        if (open_r) begin
          msum_nxt = msum_upd;
        end else begin
          out_data_nxt.status       = simrg_pkg::STAT_EMPTY;
          out_data_nxt.out_seq      = '0;
          out_data_nxt.out_start    = '0;
          out_data_nxt.out_end      = '0;
          out_data_nxt.merged_total = msum_r;
        end
      end
      simrg_pkg::OP_ERR: begin
        emit                      = 1'b1;
        out_data_nxt.status       = simrg_pkg::STAT_UNSORTED;
        out_data_nxt.out_seq      = q_head.seq;
        out_data_nxt.out_start    = q_head.start;
        out_data_nxt.out_end      = q_head.stop;
        out_data_nxt.merged_total = msum_r;
      end
      simrg_pkg::OP_IV: begin
        if (new_block) begin
          emit       = open_r;
          msum_nxt   = open_r ? msum_upd : msum_r;
          open_nxt   = 1'b1;
          bseq_nxt   = q_head.seq;
          bstart_nxt = q_head.start;
          bend_nxt   = q_head.stop;
        end else if (q_head.stop > bend_r) begin
          bend_nxt = q_head.stop;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    out_valid_nxt = (out_valid_r && out_stall) || (pop && emit);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bseq_r   <= bseq_nxt;
      bstart_r <= bstart_nxt;
      bend_r   <= bend_nxt;
    end
    if (pop && emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      msum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        open_r <= open_nxt;
        msum_r <= msum_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
